/* src/swbc_pkg.sv */
`timescale 1ns / 1ps

package swbc_pkg;

   localparam int SYMBOL_W = 8;
   localparam int CFG_W    = 11;
   localparam int TOTAL_W  = 32;
   localparam int CODE_W   = 3;
   localparam int LETTERS  = 4;

   localparam logic [SYMBOL_W-1:0] CHAR_A = 8'h41;
   localparam logic [SYMBOL_W-1:0] CHAR_C = 8'h43;
   localparam logic [SYMBOL_W-1:0] CHAR_G = 8'h47;
   localparam logic [SYMBOL_W-1:0] CHAR_T = 8'h54;

   localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
   localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
   localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
   localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
   localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_A         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_C         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_G         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_T         = 3'd4;

   typedef logic [CODE_W-1:0] code_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } req_type;

   typedef struct packed {
      logic               window_full;
      logic               window_ok;
      logic [TOTAL_W-1:0] match_total;
      logic               last_out;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] window_length;
      logic [CFG_W-1:0] min_a;
      logic [CFG_W-1:0] min_c;
      logic [CFG_W-1:0] min_g;
      logic [CFG_W-1:0] min_t;
   } cfg_type;

   // second-stage control handed to the tally
   typedef struct packed {
      logic     advance;
      code_type code;
      logic     drop;
      logic     full;
      logic     last;
   } tally_ctrl_type;

   function automatic code_type encode_symbol(input logic [SYMBOL_W-1:0] sym);
      code_type c;
      case (sym)
         CHAR_A:  c = CODE_A;
         CHAR_C:  c = CODE_C;
         CHAR_G:  c = CODE_G;
         CHAR_T:  c = CODE_T;
         default: c = CODE_OTHER;
      endcase
      return c;
   endfunction

endpackage

/* src/swbc_ring.sv */
`timescale 1ns / 1ps

module swbc_ring #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  swbc_pkg::code_type       wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output swbc_pkg::code_type       rd_data
);
   import swbc_pkg::*;

   code_type mem [DEPTH];
   code_type rd_data_ff;

   // read-before-write on a shared address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/swbc_tally.sv */
`timescale 1ns / 1ps

module swbc_tally #(
   parameter int CNT_W = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  swbc_pkg::tally_ctrl_type ctrl,
   input  swbc_pkg::code_type       old_code,
   input  swbc_pkg::cfg_type        cfg,
   output swbc_pkg::rsp_type        result
);
   import swbc_pkg::*;

   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   logic [CNT_W-1:0]   counts_ff [LETTERS];
   logic [CNT_W-1:0]   counts_in [LETTERS];
   logic [CFG_W-1:0]   mins      [LETTERS];
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic               meets;

   always_comb begin
      mins[0] = cfg.min_a;
      mins[1] = cfg.min_c;
      mins[2] = cfg.min_g;
      mins[3] = cfg.min_t;
      meets = ctrl.full;
      for (int k = 0; k < LETTERS; k++) begin
         counts_in[k] = counts_ff[k];
         if (ctrl.drop && old_code == CODE_W'(k) && counts_ff[k] != '0) begin
            counts_in[k] = counts_in[k] - 1'b1;
         end
         if (ctrl.code == CODE_W'(k)) begin
            counts_in[k] = counts_in[k] + 1'b1;
         end
         if (CMP_W'(counts_in[k]) < CMP_W'(mins[k])) begin
            meets = 1'b0;
         end
      end
      total_in = (meets && total_ff != '1) ? total_ff + 1'b1 : total_ff;
      result.window_full = ctrl.full;
      result.window_ok   = meets;
      result.match_total = total_in;
      result.last_out    = ctrl.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LETTERS; k++) begin
            counts_ff[k] <= '0;
         end
         total_ff <= '0;
      end else if (ctrl.advance) begin
         for (int k = 0; k < LETTERS; k++) begin
            counts_ff[k] <= ctrl.last ? '0 : counts_in[k];
         end
         total_ff <= ctrl.last ? '0 : total_in;
      end
   end

endmodule

/* src/sliding_window_base_composition.sv */
`timescale 1ns / 1ps

// Sliding-window base-composition counter. One symbol transaction is taken
// per clock while rsp_ready stays high; its response passes through the
// stage-one and output registers. The history ring does its registered read
// of the oldest symbol at the accepting edge, and the letter-count update
// and qualification are registered as the stage-one entry moves on to the
// output register. With rsp_ready low, at most two transactions are held
// and req_ready drops until the response is taken. The ring sits in a single
// synchronous memory of WINDOW_MAX 3-bit entries. The fill level guarantees
// that only entries written in the current sequence are used, so there is
// no clearing pass after reset or after a last transaction. Configuration
// writes are accepted in any cycle and must only be issued while idle.

module sliding_window_base_composition #(
   parameter int WINDOW_MAX = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  swbc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output swbc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swbc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [swbc_pkg::CFG_W-1:0]            csr_data
);
   import swbc_pkg::*;

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int FW = $clog2(WINDOW_MAX + 1);
   localparam int LW = (FW > CFG_W) ? FW : CFG_W;
   localparam int IW = AW + 1;

   cfg_type         cfg_ff;
   logic [AW-1:0]   wp_ff, wp_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [LW-1:0]   len_eff;
   logic [FW-1:0]   fill_next;
   logic [IW-1:0]   old_idx;
   logic            drop;
   code_type        new_code;
   code_type        old_code;

   logic            s1_valid_ff, s1_valid_in;
   tally_ctrl_type  s1_ff;
   tally_ctrl_type  tally_ctrl;
   rsp_type         result;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff;

   logic            req_fire, out_ready, s1_fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length <= CFG_W'(1);
         cfg_ff.min_a         <= '0;
         cfg_ff.min_c         <= '0;
         cfg_ff.min_g         <= '0;
         cfg_ff.min_t         <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WINDOW_LENGTH: cfg_ff.window_length <= csr_data;
            REG_MIN_A:         cfg_ff.min_a         <= csr_data;
            REG_MIN_C:         cfg_ff.min_c         <= csr_data;
            REG_MIN_G:         cfg_ff.min_g         <= csr_data;
            REG_MIN_T:         cfg_ff.min_t         <= csr_data;
            default:           ;
         endcase
      end
   end

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_ready;
   assign req_ready = !s1_valid_ff || out_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (cfg_ff.window_length == '0) begin
         len_eff = LW'(1);
      end else if (LW'(cfg_ff.window_length) > LW'(WINDOW_MAX)) begin
         len_eff = LW'(WINDOW_MAX);
      end else begin
         len_eff = LW'(cfg_ff.window_length);
      end
      drop      = LW'(fill_ff) >= len_eff;
      fill_next = drop ? fill_ff : fill_ff + 1'b1;
      if (IW'(wp_ff) >= IW'(fill_ff)) begin
         old_idx = IW'(wp_ff) - IW'(fill_ff);
      end else begin
         old_idx = IW'(wp_ff) + IW'(WINDOW_MAX) - IW'(fill_ff);
      end
      new_code = encode_symbol(req_data.symbol);
      if (req_data.last) begin
         wp_in   = '0;
         fill_in = '0;
      end else begin
         wp_in   = (wp_ff == AW'(WINDOW_MAX - 1)) ? '0 : wp_ff + 1'b1;
         fill_in = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (req_fire) begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   swbc_ring #(
      .DEPTH  (WINDOW_MAX),
      .ADDR_W (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (wp_ff),
      .wr_data (new_code),
      .rd_en   (req_fire),
      .rd_addr (old_idx[AW-1:0]),
      .rd_data (old_code)
   );

   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff.advance <= 1'b0;
         s1_ff.code    <= new_code;
         s1_ff.drop    <= drop;
         s1_ff.full    <= LW'(fill_next) >= len_eff;
         s1_ff.last    <= req_data.last;
      end
   end

   always_comb begin
      tally_ctrl         = s1_ff;
      tally_ctrl.advance = s1_fire;
   end

   swbc_tally #(
      .CNT_W (FW)
   ) u_tally (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tally_ctrl),
      .old_code (old_code),
      .cfg      (cfg_ff),
      .result   (result)
   );

   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/swbc_checker.sv */
`timescale 1ns / 1ps

module swbc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  swbc_pkg::rsp_type                rsp_data
);
   import swbc_pkg::*;

   logic [1:0] flight_ff, flight_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      flight_in = flight_ff;
      if (req_fire && !rsp_fire) begin
         flight_in = flight_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         flight_in = flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_ok_needs_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.window_ok || rsp_data.window_full)
      else $error("window_ok without window_full");

   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      flight_ff <= 2'd2)
      else $error("more than two transactions in flight");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> flight_ff != 2'd0)
      else $error("response without an accepted request");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sliding_window_base_composition swbc_checker u_swbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* bench/sliding_window_base_composition_tb.sv */
`timescale 1ns / 1ps

module sliding_window_base_composition_tb;
   import swbc_pkg::*;

   localparam int RING_DEPTH    = 1024;
   localparam int PTR_W         = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int REPORT_MAX    = 10;
   localparam int SMALL_PHASES  = 4;
   localparam int PHASE_ITEMS   = 8;
   localparam int BIG_FILL      = 1030;

   localparam logic [CSR_INDEX_W-1:0] REG_NONE = 3'd7;

   typedef enum logic [1:0] {
      STEP_SYMBOL,
      STEP_CSR,
      STEP_DRAIN,
      STEP_MODE
   } step_kind_type;

   typedef struct packed {
      step_kind_type          kind;
      req_type                symbol_item;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CFG_W-1:0]       csr_value;
      logic [6:0]             send_idle;
      logic [6:0]             recv_stall;
   } plan_step_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data  = '0;

   plan_step_type plan[$];
   rsp_type       expected_rsp[$];
   logic          plan_done      = 1'b0;
   int unsigned   send_idle_pct  = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count    = 0;
   int unsigned   settle_count   = 0;

   // predictor state
   cfg_type            cfg_shadow;
   code_type           ring_codes[RING_DEPTH];
   logic [PTR_W-1:0]   ring_wptr;
   logic [CFG_W-1:0]   ring_fill;
   logic [CFG_W-1:0]   base_count[LETTERS];
   logic [TOTAL_W-1:0] window_tally;

   sliding_window_base_composition u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   function automatic void clear_sequence();
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_codes[i] = CODE_A;
      end
      for (int i = 0; i < LETTERS; i++) begin
         base_count[i] = '0;
      end
      ring_wptr    = '0;
      ring_fill    = '0;
      window_tally = '0;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CFG_W-1:0] value);
      case (idx)
         REG_WINDOW_LENGTH: cfg_shadow.window_length = value;
         REG_MIN_A:         cfg_shadow.min_a = value;
         REG_MIN_C:         cfg_shadow.min_c = value;
         REG_MIN_G:         cfg_shadow.min_g = value;
         REG_MIN_T:         cfg_shadow.min_t = value;
         default: ;
      endcase
   endfunction

   function automatic rsp_type predict_window(input req_type item);
      logic [CFG_W-1:0] eff_len;
      code_type         code;
      code_type         old_code;
      logic [PTR_W-1:0] old_idx;
      logic             full;
      logic             ok;
      rsp_type          res;
      eff_len = cfg_shadow.window_length;
      if (eff_len == '0) begin
         eff_len = CFG_W'(1);
      end else if (eff_len > RING_DEPTH) begin
         eff_len = CFG_W'(RING_DEPTH);
      end
      case (item.symbol)
         CHAR_A:  code = CODE_A;
         CHAR_C:  code = CODE_C;
         CHAR_G:  code = CODE_G;
         CHAR_T:  code = CODE_T;
         default: code = CODE_OTHER;
      endcase
      if (ring_fill >= eff_len) begin
         old_idx  = ring_wptr - ring_fill[PTR_W-1:0];
         old_code = ring_codes[old_idx];
         if (old_code < CODE_OTHER && base_count[old_code[1:0]] != '0) begin
            base_count[old_code[1:0]] = base_count[old_code[1:0]] - 1'b1;
         end
      end else begin
         ring_fill = ring_fill + 1'b1;
      end
      ring_codes[ring_wptr] = code;
      ring_wptr = ring_wptr + 1'b1;
      if (code < CODE_OTHER) begin
         base_count[code[1:0]] = base_count[code[1:0]] + 1'b1;
      end
      full = (ring_fill >= eff_len);
      ok = full &&
           base_count[CODE_A[1:0]] >= cfg_shadow.min_a &&
           base_count[CODE_C[1:0]] >= cfg_shadow.min_c &&
           base_count[CODE_G[1:0]] >= cfg_shadow.min_g &&
           base_count[CODE_T[1:0]] >= cfg_shadow.min_t;
      if (ok && window_tally != '1) begin
         window_tally = window_tally + 1'b1;
      end
      res.window_full = full;
      res.window_ok   = ok;
      res.match_total = window_tally;
      res.last_out    = item.last;
      if (item.last) begin
         clear_sequence();
      end
      return res;
   endfunction

   function automatic void add_symbol(input logic [SYMBOL_W-1:0] sym, input logic last);
      plan_step_type s;
      s = '0;
      s.kind = STEP_SYMBOL;
      s.symbol_item.symbol = sym;
      s.symbol_item.last = last;
      plan.push_back(s);
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CFG_W-1:0] value);
      plan_step_type s;
      s = '0;
      s.kind = STEP_CSR;
      s.csr_idx = idx;
      s.csr_value = value;
      plan.push_back(s);
   endfunction

   function automatic void add_drain();
      plan_step_type s;
      s = '0;
      s.kind = STEP_DRAIN;
      plan.push_back(s);
   endfunction

   function automatic void add_mode(input int unsigned idle, input int unsigned stall);
      plan_step_type s;
      s = '0;
      s.kind = STEP_MODE;
      s.send_idle = idle[6:0];
      s.recv_stall = stall[6:0];
      plan.push_back(s);
   endfunction

   // mostly bases, some arbitrary bytes
   function automatic logic [SYMBOL_W-1:0] random_symbol();
      logic [SYMBOL_W-1:0] sym;
      if ($urandom_range(0, 19) < 3) begin
         sym = SYMBOL_W'($urandom_range(0, 255));
      end else begin
         case ($urandom_range(0, 3))
            0:       sym = CHAR_A;
            1:       sym = CHAR_C;
            2:       sym = CHAR_G;
            default: sym = CHAR_T;
         endcase
      end
      return sym;
   endfunction

   initial begin : clock_gen
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sliding_window_base_composition] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin : driver
      logic          nxt_req_valid;
      logic          nxt_csr_valid;
      plan_step_type head;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         plan_done <= 1'b0;
         settle_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_window(req_data));
         end
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
         end
         nxt_req_valid = req_valid && !req_ready;
         nxt_csr_valid = csr_valid && !csr_ready;
         if (!nxt_req_valid && !nxt_csr_valid && plan.size() != 0) begin
            head = plan[0];
            case (head.kind)
               STEP_MODE: begin
                  send_idle_pct  = 32'(head.send_idle);
                  recv_stall_pct = 32'(head.recv_stall);
                  void'(plan.pop_front());
               end
               STEP_DRAIN: begin
                  if (expected_rsp.size() == 0) begin
                     settle_count++;
                  end else begin
                     settle_count = 0;
                  end
                  if (settle_count >= SETTLE_CYCLES) begin
                     settle_count = 0;
                     void'(plan.pop_front());
                  end
               end
               STEP_SYMBOL: begin
                  if ($urandom_range(0, 99) >= send_idle_pct) begin
                     req_data <= head.symbol_item;
                     nxt_req_valid = 1'b1;
                     void'(plan.pop_front());
                  end
               end
               default: begin
                  csr_index <= head.csr_idx;
                  csr_data <= head.csr_value;
                  nxt_csr_valid = 1'b1;
                  void'(plan.pop_front());
               end
            endcase
         end
         req_valid <= nxt_req_valid;
         csr_valid <= nxt_csr_valid;
         plan_done <= !nxt_req_valid && !nxt_csr_valid && plan.size() == 0;
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
               $display("unexpected transaction: full %0d ok %0d total %0d last %0d",
                        rsp_data.window_full, rsp_data.window_ok,
                        rsp_data.match_total, rsp_data.last_out);
            end
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.window_full !== want.window_full ||
                rsp_data.window_ok   !== want.window_ok ||
                rsp_data.match_total !== want.match_total ||
                rsp_data.last_out    !== want.last_out) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display({"mismatch: exp full %0d ok %0d total %0d last %0d,",
                            " got full %0d ok %0d total %0d last %0d"},
                           want.window_full, want.window_ok, want.match_total,
                           want.last_out, rsp_data.window_full, rsp_data.window_ok,
                           rsp_data.match_total, rsp_data.last_out);
               end
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned len;
      int unsigned idle_tab[4];
      int unsigned stall_tab[4];
      logic [CFG_W-1:0] min_val;

      cfg_shadow = '0;
      cfg_shadow.window_length = CFG_W'(1);
      clear_sequence();
      idle_tab  = '{0, 50, 0, 26};
      stall_tab = '{0, 0, 50, 26};

      // reset configuration: one-symbol windows, every letter and three other bytes
      add_mode(0, 0);
      add_symbol(CHAR_A, 1'b0);
      add_symbol(CHAR_C, 1'b0);
      add_symbol(CHAR_G, 1'b0);
      add_symbol(CHAR_T, 1'b0);
      add_symbol(8'h00, 1'b0);
      add_symbol(8'hFF, 1'b0);
      add_symbol(8'h61, 1'b1);
      // zero length acts as one
      add_drain();
      add_csr(REG_WINDOW_LENGTH, 11'd0);
      add_csr(REG_MIN_A, 11'd1);
      add_symbol(CHAR_A, 1'b0);
      add_symbol(CHAR_C, 1'b0);
      add_symbol(CHAR_A, 1'b1);
      add_drain();
      add_csr(REG_WINDOW_LENGTH, 11'd4);
      add_csr(REG_MIN_C, 11'd1);
      add_csr(REG_MIN_G, 11'd1);
      add_csr(REG_MIN_T, 11'd1);
      add_csr(REG_NONE, 11'h7FF);
      add_symbol(CHAR_A, 1'b0);
      add_symbol(CHAR_C, 1'b0);
      add_symbol(CHAR_G, 1'b0);
      add_symbol(CHAR_T, 1'b0);
      add_symbol(8'h4E, 1'b0);
      add_symbol(CHAR_A, 1'b0);
      add_symbol(CHAR_C, 1'b0);
      add_symbol(CHAR_G, 1'b0);
      add_symbol(CHAR_T, 1'b1);
      // minimum above the window length
      add_drain();
      add_csr(REG_MIN_T, 11'd5);
      add_symbol(CHAR_T, 1'b0);
      add_symbol(CHAR_T, 1'b0);
      add_symbol(CHAR_T, 1'b0);
      add_symbol(CHAR_T, 1'b1);
      // length beyond the ring depth, min_a at top
      add_drain();
      add_csr(REG_WINDOW_LENGTH, 11'h7FF);
      add_csr(REG_MIN_A, 11'h7FF);
      add_symbol(CHAR_G, 1'b0);
      add_symbol(CHAR_C, 1'b1);

      for (int p = 0; p < SMALL_PHASES; p++) begin
         add_drain();
         add_mode(idle_tab[p % 4], stall_tab[p % 4]);
         case ($urandom_range(0, 5))
            0:       len = 0;
            1:       len = 1;
            5:       len = $urandom_range(17, 64);
            default: len = $urandom_range(2, 16);
         endcase
         add_csr(REG_WINDOW_LENGTH, CFG_W'(len));
         for (int r = REG_MIN_A; r <= REG_MIN_T; r++) begin
            case ($urandom_range(0, 19))
               0:       min_val = '0;
               18:      min_val = CFG_W'(len + 1);
               19:      min_val = CFG_W'($urandom_range(0, 2047));
               default: min_val = CFG_W'($urandom_range(0, (len + 3) / 4));
            endcase
            add_csr(CSR_INDEX_W'(r), min_val);
         end
         if ($urandom_range(0, 5) == 0) begin
            add_csr(CSR_INDEX_W'($urandom_range(5, 7)), CFG_W'($urandom_range(0, 2047)));
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ((p == 0 && i == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0) begin
               add_drain();
            end
            add_symbol(random_symbol(), $urandom_range(0, 24) == 0);
         end
         // on a coin toss a phase ends without a closing last symbol, leaving the sequence open across the next write
         if ($urandom_range(0, 1) == 1) begin
            add_symbol(random_symbol(), 1'b1);
         end
      end

      // full-depth window with ring wrap, then shrink mid-sequence
      add_drain();
      add_mode(26, 26);
      add_symbol(CHAR_A, 1'b1);
      add_drain();
      add_csr(REG_WINDOW_LENGTH, 11'd1024);
      add_csr(REG_MIN_A, CFG_W'($urandom_range(200, 225)));
      add_csr(REG_MIN_C, CFG_W'($urandom_range(200, 225)));
      add_csr(REG_MIN_G, CFG_W'($urandom_range(200, 225)));
      add_csr(REG_MIN_T, CFG_W'($urandom_range(200, 225)));
      for (int i = 0; i < BIG_FILL; i++) begin
         add_symbol(random_symbol(), 1'b0);
      end
      add_drain();
      add_csr(REG_WINDOW_LENGTH, 11'd3);
      for (int i = 0; i < 20; i++) begin
         add_symbol(random_symbol(), i == 19);
      end
      add_drain();
      add_csr(REG_MIN_A, 11'd0);
      add_csr(REG_MIN_C, 11'd0);
      add_csr(REG_MIN_G, 11'd1);
      add_csr(REG_MIN_T, 11'd0);
      for (int i = 0; i < 10; i++) begin
         add_symbol(random_symbol(), i == 9);
      end
      add_drain();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!plan_done) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatch_count += expected_rsp.size();
      if (mismatch_count == 0) begin
         $display("[sliding_window_base_composition] OK");
      end else begin
         $display("[sliding_window_base_composition] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
src/swbc_pkg.sv
src/swbc_ring.sv
src/swbc_tally.sv
src/sliding_window_base_composition.sv
src/swbc_checker.sv
bench/sliding_window_base_composition_tb.sv
